// ===== hw/rtl/sensor_window_extremes_reporter_unit_macros.svh =====
// Assertion macros for the sensor window extremes reporter.
// Needs clk_i and rst_ni in the including scope.
`ifndef SENSOR_WINDOW_EXTREMES_REPORTER_UNIT_MACROS_SVH
`define SENSOR_WINDOW_EXTREMES_REPORTER_UNIT_MACROS_SVH

// same-cycle implication
`define SWER_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swer assertion failed");

// next-cycle implication
`define SWER_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swer assertion failed");

`endif

// ===== hw/rtl/swer_pkg.sv =====
// Shared types and constants for the sensor window extremes reporter.
// No dependencies.
package swer_pkg;

  localparam int unsigned SENSOR_COUNT  = 8;
  localparam int unsigned SPREAD_WINDOW = 10;
  localparam int unsigned HOUR_WINDOW   = 60;
  localparam int unsigned TOP_COUNT     = 5;

  localparam int unsigned TEMP_W     = 8;
  localparam int unsigned IN_TDATA_W = 64;
  localparam int unsigned VALUE_W    = 9;
  localparam int unsigned RANK_W     = 3;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_SPREAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TOP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BOTTOM = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SSCAN,
    ST_SEMIT,
    ST_HSCAN,
    ST_HEMIT
  } state_e;

endpackage

// ===== hw/rtl/swer_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module swer_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/sensor_window_extremes_reporter_unit.sv =====
// Sensor window extremes reporter: per-period min/max into RAM rings, ranked reports.
// Items are taken in ST_IDLE and written to both rings in ST_UPDATE. A period that closes
// the spread window adds a scan of the spread ring; an hourly report adds
// 2*min(TopCount, HourWindow) scans of the hour ring, one per ranked value, as each ring
// has a single read port. Reset: asynchronous, active low; clears ring positions and
// control, not the ring contents.
`include "sensor_window_extremes_reporter_unit_macros.svh"

module sensor_window_extremes_reporter_unit #(
  parameter int unsigned SensorCount  = swer_pkg::SENSOR_COUNT,
  parameter int unsigned SpreadWindow = swer_pkg::SPREAD_WINDOW,
  parameter int unsigned HourWindow   = swer_pkg::HOUR_WINDOW,
  parameter int unsigned TopCount     = swer_pkg::TOP_COUNT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // temp_0 [7:0], temp_1 [15:8], ... temp_7 [63:56]
  input  logic [swer_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // value [8:0], rank [11:9], zero [15:12]
  output logic [swer_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // report_kind [1:0]
  output logic [swer_pkg::KIND_W-1:0]        m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);

  localparam int unsigned TW     = swer_pkg::TEMP_W;
  localparam int unsigned SpAw   = $clog2(SpreadWindow);
  localparam int unsigned HrAw   = $clog2(HourWindow);
  localparam int unsigned ScanLen = (HourWindow > SpreadWindow) ? HourWindow : SpreadWindow;
  localparam int unsigned ScanW  = $clog2(ScanLen);
  localparam int unsigned CntW   = $clog2(HourWindow + 1);
  localparam int unsigned NRank  = (TopCount < HourWindow) ? TopCount : HourWindow;
  localparam int unsigned RkW    = (NRank > 1) ? $clog2(NRank) : 1;

  localparam logic [SpAw-1:0]  SpLast   = SpAw'(SpreadWindow - 1);
  localparam logic [HrAw-1:0]  HrLast   = HrAw'(HourWindow - 1);
  localparam logic [ScanW-1:0] SpScanEnd = ScanW'(SpreadWindow - 1);
  localparam logic [ScanW-1:0] HrScanEnd = ScanW'(HourWindow - 1);
  localparam logic [RkW-1:0]   RkLast   = RkW'(NRank - 1);

  swer_pkg::state_e state_q, state_d;

  // --- input min/max, taken at the transfer
  logic signed [TW-1:0] in_lo, in_hi;
  always_comb begin
    in_lo = s_axis_tdata_i[TW-1:0];
    in_hi = s_axis_tdata_i[TW-1:0];
    for (int unsigned s = 1; s < SensorCount; s++) begin
      if ($signed(s_axis_tdata_i[s*TW +: TW]) < in_lo) in_lo = s_axis_tdata_i[s*TW +: TW];
      if ($signed(s_axis_tdata_i[s*TW +: TW]) > in_hi) in_hi = s_axis_tdata_i[s*TW +: TW];
    end
  end

  logic signed [TW-1:0] lo_q, hi_q;
  logic [SpAw-1:0] sp_pos_q;
  logic [HrAw-1:0] hr_pos_q;
  logic            hr_rep_q;

  // scan control
  logic [ScanW-1:0] idx_q;
  logic             issuing_q;
  logic             rd_v_q, rd_last_q;
  logic             dir_max_q;          // 1: maxima pass, 0: minima pass
  logic [RkW-1:0]   rank_q;

  // accumulators
  logic [TW-1:0]        sp_best_q;
  logic signed [TW-1:0] cand_q, prev_q;
  logic                 cand_found_q, have_prev_q;
  logic [CntW-1:0]      cnt_eq_q, used_q;
  logic                 done_q;         // last read beat consumed

  // outputs of the output decode block
  logic in_take, ram_we, scan_start, load_out;

  // --- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      swer_pkg::ST_IDLE:   if (s_axis_tvalid_i) state_d = swer_pkg::ST_UPDATE;
      swer_pkg::ST_UPDATE: begin
        if (sp_pos_q == SpLast)      state_d = swer_pkg::ST_SSCAN;
        else if (hr_pos_q == HrLast) state_d = swer_pkg::ST_HSCAN;
        else                         state_d = swer_pkg::ST_IDLE;
      end
      swer_pkg::ST_SSCAN:  if (done_q) state_d = swer_pkg::ST_SEMIT;
      swer_pkg::ST_SEMIT:  if (load_out) begin
        state_d = hr_rep_q ? swer_pkg::ST_HSCAN : swer_pkg::ST_IDLE;
      end
      swer_pkg::ST_HSCAN:  if (done_q) state_d = swer_pkg::ST_HEMIT;
      swer_pkg::ST_HEMIT:  if (load_out) begin
        state_d = (!dir_max_q && rank_q == RkLast) ? swer_pkg::ST_IDLE : swer_pkg::ST_HSCAN;
      end
      default: state_d = swer_pkg::ST_IDLE;
    endcase
  end

  logic out_valid_q;

  // --- control outputs
  always_comb begin
    in_take    = 1'b0;
    ram_we     = 1'b0;
    scan_start = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      swer_pkg::ST_IDLE:   in_take = s_axis_tvalid_i;
      swer_pkg::ST_UPDATE: begin
        ram_we     = 1'b1;
        scan_start = (sp_pos_q == SpLast) || (hr_pos_q == HrLast);
      end
      // a new scan starts only when another report follows
      swer_pkg::ST_SEMIT: begin
        load_out   = !out_valid_q || m_axis_tready_i;
        scan_start = load_out && hr_rep_q;
      end
      swer_pkg::ST_HEMIT: begin
        load_out   = !out_valid_q || m_axis_tready_i;
        scan_start = load_out && !(!dir_max_q && rank_q == RkLast);
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == swer_pkg::ST_IDLE);

  // --- rings
  logic [TW-1:0]   sp_rdata;
  logic [2*TW-1:0] hr_rdata;
  logic            rd_en;

  assign rd_en = issuing_q;

  swer_ram #(.Width(TW), .Depth(SpreadWindow)) u_spread_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(sp_pos_q),
    .wdata_i(hi_q - lo_q),
    .re_i   (rd_en && state_q == swer_pkg::ST_SSCAN),
    .raddr_i(idx_q[SpAw-1:0]),
    .rdata_o(sp_rdata)
  );

  // {max, min} per period
  swer_ram #(.Width(2*TW), .Depth(HourWindow)) u_hour_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(hr_pos_q),
    .wdata_i({hi_q, lo_q}),
    .re_i   (rd_en && state_q == swer_pkg::ST_HSCAN),
    .raddr_i(idx_q[HrAw-1:0]),
    .rdata_o(hr_rdata)
  );

  // --- scan datapath
  logic signed [TW-1:0] x;
  logic                 elig, better_x, is_eq;
  assign x        = dir_max_q ? hr_rdata[2*TW-1:TW] : hr_rdata[TW-1:0];
  assign elig     = !have_prev_q || (dir_max_q ? (x < prev_q) : (x > prev_q));
  assign better_x = !cand_found_q || (dir_max_q ? (x > cand_q) : (x < cand_q));
  assign is_eq    = have_prev_q && (x == prev_q);

  logic                 repeat_prev;
  logic signed [TW-1:0] hr_value;
  assign repeat_prev = have_prev_q && (cnt_eq_q > used_q);
  assign hr_value    = repeat_prev ? prev_q : cand_q;

  logic [ScanW-1:0] scan_end;
  assign scan_end = (state_q == swer_pkg::ST_SSCAN) ? SpScanEnd : HrScanEnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swer_pkg::ST_IDLE;
      sp_pos_q    <= '0;
      hr_pos_q    <= '0;
      hr_rep_q    <= 1'b0;
      issuing_q   <= 1'b0;
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
      done_q      <= 1'b0;
      dir_max_q   <= 1'b1;
      rank_q      <= '0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        sp_pos_q  <= (sp_pos_q == SpLast) ? '0 : sp_pos_q + 1'b1;
        hr_pos_q  <= (hr_pos_q == HrLast) ? '0 : hr_pos_q + 1'b1;
        hr_rep_q  <= (hr_pos_q == HrLast);
        dir_max_q   <= 1'b1;
        rank_q      <= '0;
        have_prev_q <= 1'b0;
      end
      // read issue, one address a cycle
      if (scan_start) begin
        issuing_q <= 1'b1;
      end else if (issuing_q && idx_q == scan_end) begin
        issuing_q <= 1'b0;
      end
      rd_v_q    <= issuing_q;
      rd_last_q <= issuing_q && idx_q == scan_end;
      done_q    <= rd_last_q && !scan_start;
      if (scan_start) done_q <= 1'b0;
      // rank bookkeeping on each hourly result
      if (load_out && state_q == swer_pkg::ST_HEMIT) begin
        have_prev_q <= 1'b1;
        if (rank_q == RkLast) begin
          rank_q      <= '0;
          dir_max_q   <= 1'b0;
          have_prev_q <= 1'b0;
        end else begin
          rank_q <= rank_q + 1'b1;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic [swer_pkg::VALUE_W-1:0] out_value_q;
  logic [swer_pkg::RANK_W-1:0]  out_rank_q;
  logic [swer_pkg::KIND_W-1:0]  out_kind_q;
  logic                         out_last_q;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      lo_q <= in_lo;
      hi_q <= in_hi;
    end
    if (scan_start) begin
      idx_q        <= '0;
      sp_best_q    <= '0;
      cand_found_q <= 1'b0;
      cnt_eq_q     <= '0;
    end else if (issuing_q) begin
      idx_q <= idx_q + 1'b1;
    end
    if (rd_v_q && !scan_start) begin
      if (state_q == swer_pkg::ST_SSCAN) begin
        if (sp_rdata > sp_best_q) sp_best_q <= sp_rdata;
      end else begin
        if (elig && better_x) begin
          cand_q       <= x;
          cand_found_q <= 1'b1;
        end
        if (is_eq) cnt_eq_q <= cnt_eq_q + 1'b1;
      end
    end
    if (load_out && state_q == swer_pkg::ST_HEMIT) begin
      if (repeat_prev) begin
        used_q <= used_q + 1'b1;
      end else begin
        prev_q <= cand_q;
        used_q <= CntW'(1);
      end
    end
    if (load_out) begin
      if (state_q == swer_pkg::ST_SEMIT) begin
        out_kind_q  <= swer_pkg::KIND_SPREAD;
        out_value_q <= {1'b0, sp_best_q};
        out_rank_q  <= '0;
        out_last_q  <= !hr_rep_q;
      end else begin
        out_kind_q  <= dir_max_q ? swer_pkg::KIND_TOP : swer_pkg::KIND_BOTTOM;
        out_value_q <= {hr_value[TW-1], hr_value};
        out_rank_q  <= swer_pkg::RANK_W'(rank_q);
        out_last_q  <= !dir_max_q && rank_q == RkLast;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(swer_pkg::OUT_TDATA_W - swer_pkg::VALUE_W - swer_pkg::RANK_W){1'b0}},
                            out_rank_q, out_value_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // --- assertions
  `SWER_ASSERT_NOW(a_beat_in_scan, rd_v_q && !rd_last_q,
                   state_q == swer_pkg::ST_SSCAN || state_q == swer_pkg::ST_HSCAN)
  `SWER_ASSERT_NEXT(a_take_then_update, s_axis_tvalid_i && s_axis_tready_o,
                    state_q == swer_pkg::ST_UPDATE)
  `SWER_ASSERT_NOW(a_spread_scan_wrapped, state_q == swer_pkg::ST_SSCAN, sp_pos_q == '0)
  `SWER_ASSERT_NOW(a_hour_scan_wrapped, state_q == swer_pkg::ST_HSCAN, hr_pos_q == '0)

endmodule
